/* design/fccr_pkg.sv */
// ---------------------------------------------------------------------------
// fccr_pkg
// Types and constants shared by the cluster chain read address generator.
// ---------------------------------------------------------------------------
package fccr_pkg;

  localparam int FAT_ENTRIES  = 65536;
  localparam int FAT_AW       = $clog2(FAT_ENTRIES);
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_W        = $clog2(MAX_SEGMENTS) + 1;

  localparam logic [15:0] CHAIN_END    = 16'hFFF8;
  localparam logic [15:0] CB_RESET     = 16'd2048;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_OPEN = 2'd1,
    KIND_SEEK = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    WH_SET = 2'd0,
    WH_CUR = 2'd1,
    WH_END = 2'd2,
    WH_NOP = 2'd3
  } whence_t;

  typedef enum logic {
    REG_CLUSTER_BYTES  = 1'b0,
    REG_DATA_AREA_BASE = 1'b1
  } reg_index_t;

  typedef struct packed {
    kind_t          kind;
    logic [15:0]    fat_index;
    logic [15:0]    fat_value;
    logic [15:0]    start_cluster;
    logic [31:0]    size_bytes;
    whence_t        whence;
    logic [31:0]    seek_offset;
    logic [14:0]    read_length;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_OPEN,
    ST_SEEK,
    ST_SEEK_DIV,
    ST_SEEK_WAIT,
    ST_WALK,
    ST_WALK_RD,
    ST_RD_START,
    ST_RD_DIV,
    ST_RD_WAIT,
    ST_RD_MUL,
    ST_RD_CALC,
    ST_RD_NEXT,
    ST_RD_LAST,
    ST_EMIT
  } state_t;

endpackage

/* design/fccr_queue.sv */
// ---------------------------------------------------------------------------
// fccr_queue
// Two-entry command queue between the front and the back.
// ---------------------------------------------------------------------------
module fccr_queue
  import fccr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/fccr_front.sv */
// ---------------------------------------------------------------------------
// fccr_front
// Input side: unpack and classify items, push them into the queue.
// ---------------------------------------------------------------------------
module fccr_front
  import fccr_pkg::*;
(
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 push_cmd
);

  assign s_tready = ~q_full;
  assign push     = s_tvalid & ~q_full;

  always_comb begin
    push_cmd               = '0;
    push_cmd.kind          = kind_t'(s_tuser);
    push_cmd.fat_index     = s_tdata[15:0];
    push_cmd.fat_value     = s_tdata[31:16];
    push_cmd.start_cluster = s_tdata[47:32];
    push_cmd.size_bytes    = s_tdata[79:48];
    push_cmd.whence        = whence_t'(s_tdata[81:80]);
    push_cmd.seek_offset   = s_tdata[113:82];
    push_cmd.read_length   = s_tdata[128:114];
    unique case (kind_t'(s_tuser))
      KIND_LOAD: begin
        push_cmd.size_bytes  = '0;
        push_cmd.seek_offset = '0;
      end
      KIND_OPEN: begin
        push_cmd.seek_offset = '0;
      end
      KIND_SEEK: begin
        push_cmd.fat_value = '0;
      end
      KIND_READ: begin
        push_cmd.fat_value = '0;
      end
      default: begin
        push_cmd.kind = KIND_LOAD;
      end
    endcase
  end

endmodule

/* design/fccr_div.sv */
// ---------------------------------------------------------------------------
// fccr_div
// Restoring divider, 32-bit dividend by 17-bit divisor, one bit a cycle.
// ---------------------------------------------------------------------------
module fccr_div
  import fccr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [15:0] remainder
);

  logic [16:0] r;
  logic [31:0] q;
  logic [16:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [17:0] shifted;
  logic        fits;

  assign shifted   = {r, q[31]};
  assign fits      = (shifted >= {1'b0, d});
  assign quotient  = q;
  assign remainder = r[15:0];

  always_ff @(posedge clk) begin
    if (start) begin
      r <= '0;
      q <= dividend;
      d <= divisor;
    end else if (busy) begin
      r <= fits ? 17'(shifted - {1'b0, d}) : shifted[16:0];
      q <= {q[30:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/fccr_engine.sv */
// ---------------------------------------------------------------------------
// fccr_engine
// Back end: FAT store, file state, chain walk and read segment generation.
// ---------------------------------------------------------------------------
module fccr_engine
  import fccr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  q_avail,
  input  cmd_t                  q_head,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  state_t state;
  state_t state_next;

  logic [15:0] cluster_bytes;
  logic [31:0] data_area_base;
  logic [16:0] cbe;

  logic [15:0] fat_mem [FAT_ENTRIES];
  logic [15:0] fat_rdata;

  cmd_t        cmd;
  logic [15:0] first_cluster;
  logic [31:0] file_length;
  logic [31:0] byte_position;
  logic [15:0] cl;

  logic [FAT_AW-1:0] steps;
  logic [FAT_AW-1:0] step_cnt;
  logic [15:0]       off;
  logic [32:0]       prod;
  logic [14:0]       done_len;
  logic [SEG_W-1:0]  seg_cnt;
  logic              advance;

  logic [33:0] emit_addr;
  logic [15:0] emit_count;
  logic        emit_last;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic [15:0] div_r;

  logic        cl_in_range;
  logic        cl_live;
  logic [15:0] fat_next;
  logic [16:0] seg_avail;
  logic [14:0] seg_remain;
  logic [15:0] seg_n;
  logic [33:0] seg_addr;
  logic        out_free;

  assign cbe         = (cluster_bytes == 16'd0) ? 17'd1 : {1'b0, cluster_bytes};
  assign cl_in_range = ({1'b0, cl} < 17'(FAT_ENTRIES));
  assign cl_live     = (cl < CHAIN_END);
  assign fat_next    = cl_in_range ? fat_rdata : CHAIN_END;
  assign seg_avail   = cbe - {1'b0, off};
  assign seg_remain  = cmd.read_length - done_len;
  assign seg_n       = ({2'b0, seg_remain} < seg_avail) ? {1'b0, seg_remain}
                                                        : seg_avail[15:0];
  assign seg_addr    = {2'b0, data_area_base} + {1'b0, prod} + {18'b0, off}
                     - {16'b0, cbe, 1'b0};
  assign out_free    = ~m_tvalid | m_tready;

  fccr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (byte_position),
    .divisor   (cbe),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_bytes  <= CB_RESET;
      data_area_base <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CLUSTER_BYTES:  cluster_bytes  <= cfg_data[15:0];
        REG_DATA_AREA_BASE: data_area_base <= cfg_data;
        default:            cluster_bytes  <= cluster_bytes;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && {1'b0, cmd.fat_index} < 17'(FAT_ENTRIES)) begin
      fat_mem[cmd.fat_index[FAT_AW-1:0]] <= cmd.fat_value;
    end
    fat_rdata <= fat_mem[cl[FAT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_avail) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            KIND_LOAD: state_next = ST_LOAD;
            KIND_OPEN: state_next = ST_OPEN;
            KIND_SEEK: state_next = ST_SEEK;
            KIND_READ: state_next = ST_RD_START;
            default:   state_next = ST_LOAD;
          endcase
        end
      end
      ST_LOAD:      state_next = ST_EMIT;
      ST_OPEN:      state_next = ST_EMIT;
      ST_SEEK:      state_next = ST_SEEK_DIV;
      ST_SEEK_DIV: begin
        div_start  = 1'b1;
        state_next = ST_SEEK_WAIT;
      end
      ST_SEEK_WAIT: begin
        if (div_done) begin
          state_next = (div_q >= 32'(FAT_ENTRIES)) ? ST_EMIT : ST_WALK;
        end
      end
      ST_WALK: begin
        state_next = (step_cnt < steps && cl_live) ? ST_WALK_RD : ST_EMIT;
      end
      ST_WALK_RD:   state_next = ST_WALK;
      ST_RD_START: begin
        state_next = (!cl_live || cmd.read_length == '0) ? ST_EMIT : ST_RD_DIV;
      end
      ST_RD_DIV: begin
        div_start  = 1'b1;
        state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (div_done) begin
          state_next = ST_RD_MUL;
        end
      end
      ST_RD_MUL:    state_next = ST_RD_CALC;
      ST_RD_CALC: begin
        state_next = (17'(off) + 17'(seg_n) == cbe) ? ST_RD_NEXT : ST_RD_LAST;
      end
      ST_RD_NEXT:   state_next = ST_RD_LAST;
      ST_RD_LAST:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (!emit_last) ? ST_RD_DIV : ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_cluster <= '0;
      file_length   <= '0;
      byte_position <= '0;
      cl            <= CHAIN_END;
      seg_cnt       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_avail) begin
            cmd <= q_head;
          end
          done_len   <= '0;
          seg_cnt    <= '0;
          emit_addr  <= '0;
          emit_count <= '0;
          emit_last  <= 1'b1;
        end
        ST_OPEN: begin
          first_cluster <= cmd.start_cluster;
          file_length   <= cmd.size_bytes;
          byte_position <= '0;
          cl            <= cmd.start_cluster;
        end
        ST_SEEK: begin
          unique case (cmd.whence)
            WH_SET:  byte_position <= cmd.seek_offset;
            WH_CUR:  byte_position <= byte_position + cmd.seek_offset;
            WH_END:  byte_position <= file_length - cmd.seek_offset;
            default: byte_position <= byte_position;
          endcase
        end
        ST_SEEK_WAIT: begin
          if (div_done) begin
            if (div_q >= 32'(FAT_ENTRIES)) begin
              cl <= CHAIN_END;
            end else begin
              steps    <= div_q[FAT_AW-1:0];
              step_cnt <= '0;
              cl       <= first_cluster;
            end
          end
        end
        ST_WALK: begin
          if (!(step_cnt < steps && cl_live) && !cl_live) begin
            cl <= CHAIN_END;
          end
        end
        ST_WALK_RD: begin
          cl       <= fat_next;
          step_cnt <= step_cnt + FAT_AW'(1);
        end
        ST_RD_WAIT: begin
          if (div_done) begin
            off <= div_r;
          end
        end
        ST_RD_MUL: begin
          prod <= {17'b0, cl} * {16'b0, cbe};
        end
        ST_RD_CALC: begin
          emit_addr     <= seg_addr;
          emit_count    <= seg_n;
          byte_position <= byte_position + 32'(seg_n);
          done_len      <= done_len + seg_n[14:0];
          seg_cnt       <= seg_cnt + SEG_W'(1);
          advance       <= (17'(off) + 17'(seg_n) == cbe);
        end
        ST_RD_NEXT: begin
          cl <= fat_next;
        end
        ST_RD_LAST: begin
          emit_last <= !(cl_live && done_len < cmd.read_length
                         && seg_cnt < SEG_W'(MAX_SEGMENTS));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {5'b0, ~cl_live, cl, byte_position, emit_count, emit_addr};
      m_tlast <= emit_last;
    end
  end

  ap_seg_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_CALC |-> seg_n != '0)
    else $error("read segment with zero bytes");

  ap_seg_limit: assert property (@(posedge clk) disable iff (rst)
    seg_cnt <= SEG_W'(MAX_SEGMENTS))
    else $error("segment count beyond limit");

  ap_len_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_LAST |-> done_len <= cmd.read_length)
    else $error("read overran its length");

  ap_div_ctx: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_SEEK_WAIT || state == ST_RD_WAIT))
    else $error("divider finished outside a wait state");

  ap_advance: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_NEXT |-> $past(state) == ST_RD_CALC && advance)
    else $error("chain advance without a used-up cluster");

endmodule

/* design/fat_cluster_chain_read_address_gen.sv */
// ---------------------------------------------------------------------------
// fat_cluster_chain_read_address_gen
// FAT16 cluster chain walker producing data-area read segments.
// ---------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready; s_tuser carries the kind (load FAT
// entry, open, seek, read) and s_tdata the packed fields. Result items leave
// on m_tvalid/m_tready with m_tlast on the final result of each input item.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write them only while idle (not enforced).
// A front stage unpacks items into a two-entry queue; the back engine holds
// the FAT in a 16-bit memory and runs one item at a time.
// Load and open go through a single work state before the emit step. A seek
// runs the 32-step divider and then walks the chain, one FAT read per step.
// A read runs the divider, one multiply and, when a cluster is used up, a
// chain fetch for each segment, up to 64 segments. An output register holds
// the current result while the engine prepares the next; a stalled receiver
// holds the engine at its emit step, and the queue keeps accepting until full.
// Reset clears the file state (no file open), the registers to their reset
// values and the queue; the FAT contents are undefined until loaded.
// ---------------------------------------------------------------------------
module fat_cluster_chain_read_address_gen
  import fccr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // fat_index, fat_value, start_cluster, size_bytes, whence, seek_offset,
  // read_length, zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // byte_address, byte_count, position, cluster_now, chain_end, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_avail;
  cmd_t q_head;

  fccr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  fccr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  fccr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
